@@ rtl/core/pwma_pkg.sv @@
package pwma_pkg;

    // Design constants of the filter and the control law.
    localparam int WINDOW_TAPS    = 4;
    localparam int SAMPLE_BITS    = 12;
    localparam int GAIN_FRAC_BITS = 16;

    // Fixed field widths.
    localparam int SP_W      = 12;
    localparam int GAIN_W    = 24;
    localparam int DUTY_W    = 12;
    localparam int FILT_W    = 14;
    localparam int CFG_IDX_W = 8;
    localparam int INT_W     = 48;

    // Widths derived from the window and sample size.
    localparam int TAP_LOG   = $clog2(WINDOW_TAPS);
    localparam int TAP_IDX_W = (TAP_LOG > 0) ? TAP_LOG : 1;
    localparam int LVL_W     = ((SP_W > SAMPLE_BITS) ? SP_W : SAMPLE_BITS) + TAP_LOG;
    localparam int ERR_W     = LVL_W + 1;
    localparam int DERR_W    = ERR_W + 1;
    localparam int P_W       = GAIN_W + 1 + ERR_W;
    localparam int D_W       = GAIN_W + 1 + DERR_W;
    localparam int PD_W      = D_W + 1;
    localparam int U_W       = INT_W + 1;

    // Output scaling: u is in units of 1/(WINDOW_TAPS * 2^GAIN_FRAC_BITS) count.
    localparam int     DUTY_MAX = (1 << DUTY_W) - 1;
    localparam longint SCALE    = longint'(WINDOW_TAPS) << GAIN_FRAC_BITS;
    localparam longint TOP_VAL  = longint'(DUTY_MAX) * SCALE;
    localparam longint LIM_VAL  = longint'(DUTY_MAX + 1) * SCALE - 1;
    localparam logic signed [U_W-1:0] U_TOP = U_W'(TOP_VAL);
    localparam logic signed [U_W-1:0] U_LIM = U_W'(LIM_VAL);

    // Division of the shifted output by WINDOW_TAPS through a reciprocal.
    localparam int     V_W     = DUTY_W + TAP_LOG;
    localparam int     DIV_SH  = V_W + TAP_LOG;
    localparam int     M_W     = V_W + 1;
    localparam int     PROD_W  = V_W + M_W;
    localparam longint DIV_MUL = (longint'(1) << DIV_SH) / WINDOW_TAPS + 1;
    localparam logic [M_W-1:0] DIV_M = M_W'(DIV_MUL);

    // Integral limits.
    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_IDX_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KP       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_KI       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_KD       = CFG_IDX_W'(3);

    // Reset values of the configuration registers.
    localparam logic [SP_W-1:0]   SETPOINT_RST = SP_W'(2000);
    localparam logic [GAIN_W-1:0] KP_RST       = GAIN_W'(52429);
    localparam logic [GAIN_W-1:0] KI_RST       = GAIN_W'(2621);
    localparam logic [GAIN_W-1:0] KD_RST       = GAIN_W'(32768);

    typedef enum logic [1:0] {
        SAT_INSIDE = 2'd0,
        SAT_ABOVE  = 2'd1,
        SAT_BELOW  = 2'd2
    } t_sat;

    typedef struct packed {
        logic [SP_W-1:0]   setpoint;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
        logic [LVL_W-1:0]         level;
    } t_qitem;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

@@ rtl/core/pid_with_moving_average_unit.sv @@
// Light-level PID controller with a moving-average input filter.
//
// Input channel: one sensor sample per item, pushed with push while full is low.
// Result channel: one result item per sample (duty, filtered level, saturation
// state), presented while empty is low and taken with pop.
// Configuration channel: i_cfg_valid with o_cfg_ready, which is always high;
// i_cfg_index selects setpoint, kp, ki*Ts or kd/Ts, other indexes are ignored.
// Registers must be written only while no item is in flight (not enforced here).
//
// Path: the queue, then the multiply, sum, integral, clamp and result registers.
// Throughput: one item per cycle unless a waiting result holds the back end.
// A four-entry queue separates the filter front end from the arithmetic back end,
// so samples are still accepted while results wait; when pop stays low the back
// end holds and the queue fills, and full rises after four more items.
// Reset clears the window, the previous error, the integral and the queue, and
// loads the default gains and setpoint.
module pid_with_moving_average_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pwma_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pwma_pkg::DUTY_W-1:0]          o_duty,
    output logic [pwma_pkg::FILT_W-1:0]          o_filtered_level,
    output logic [1:0]                           o_saturation,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pwma_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pwma_pkg::GAIN_W-1:0]          i_cfg_data
);
    import pwma_pkg::*;

    t_cfg    r_cfg;
    t_qitem  front_item;
    t_qitem  q_item;
    t_q_stat q_stat;
    t_sat    res_sat;
    logic    in_accept;
    logic    back_take;
    logic    res_valid;
    logic    res_pop;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !q_stat.full;
    assign full        = q_stat.full;
    assign empty       = !res_valid;
    assign res_pop     = pop && res_valid;
    assign o_saturation = res_sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint <= SETPOINT_RST;
            r_cfg.kp       <= KP_RST;
            r_cfg.ki       <= KI_RST;
            r_cfg.kd       <= KD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SETPOINT: r_cfg.setpoint <= i_cfg_data[SP_W-1:0];
                REG_KP:       r_cfg.kp       <= i_cfg_data;
                REG_KI:       r_cfg.ki       <= i_cfg_data;
                REG_KD:       r_cfg.kd       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pwma_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .o_item   (front_item)
    );

    pwma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (front_item),
        .i_pop   (back_take),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    pwma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (!q_stat.empty),
        .i_item      (q_item),
        .o_take      (back_take),
        .i_res_pop   (res_pop),
        .o_res_valid (res_valid),
        .o_duty      (o_duty),
        .o_level     (o_filtered_level),
        .o_sat       (res_sat)
    );

    // Reset leaves both channels idle.
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("channels not idle after reset");

    // The queue fill count never passes its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count exceeds depth");

    // The filtered level of a waiting result stays within the window's range.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_filtered_level <= FILT_W'(WINDOW_TAPS * ((1 << SAMPLE_BITS) - 1)))
        else $error("filtered level out of range");

    // The back end never takes an item from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !back_take)
        else $error("back end read an empty queue");

endmodule

@@ rtl/core/pwma_front.sv @@
module pwma_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [pwma_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  pwma_pkg::t_cfg                    i_cfg,
    output pwma_pkg::t_qitem                  o_item
);
    import pwma_pkg::*;

    logic [SAMPLE_BITS-1:0]   r_window [WINDOW_TAPS];
    logic [TAP_IDX_W-1:0]     r_slot;
    logic [LVL_W-1:0]         r_sum;
    logic signed [ERR_W-1:0]  r_prev_err;

    logic [LVL_W-1:0]         n_sum;
    logic [TAP_IDX_W-1:0]     n_slot;
    logic [LVL_W-1:0]         sp_level;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;

    // Running window sum after the new sample replaces the oldest one.
    assign n_sum  = r_sum - LVL_W'(r_window[r_slot]) + LVL_W'(i_sample);
    assign n_slot = (r_slot == TAP_IDX_W'(WINDOW_TAPS - 1)) ? '0 : r_slot + 1'b1;

    // Error against the setpoint in window units, and its change since the last tick.
    assign sp_level = LVL_W'(LVL_W'(i_cfg.setpoint) * LVL_W'(WINDOW_TAPS));
    assign err      = $signed({1'b0, sp_level}) - $signed({1'b0, n_sum});
    assign derr     = DERR_W'(err) - DERR_W'(r_prev_err);

    assign o_item.err   = err;
    assign o_item.derr  = derr;
    assign o_item.level = n_sum;

    // Filter state advances on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_TAPS; k++) begin
                r_window[k] <= '0;
            end
            r_slot     <= '0;
            r_sum      <= '0;
            r_prev_err <= '0;
        end else if (i_accept) begin
            r_window[r_slot] <= i_sample;
            r_slot           <= n_slot;
            r_sum            <= n_sum;
            r_prev_err       <= err;
        end
    end

endmodule

@@ rtl/core/pwma_queue.sv @@
module pwma_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pwma_pkg::t_qitem   i_item,
    input  logic               i_pop,
    output pwma_pkg::t_qitem   o_item,
    output pwma_pkg::t_q_stat  o_stat
);
    import pwma_pkg::*;

    t_qitem             r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr;
    logic [Q_IDX_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/pwma_back.sv @@
module pwma_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwma_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  pwma_pkg::t_qitem              i_item,
    output logic                          o_take,
    input  logic                          i_res_pop,
    output logic                          o_res_valid,
    output logic [pwma_pkg::DUTY_W-1:0]   o_duty,
    output logic [pwma_pkg::FILT_W-1:0]   o_level,
    output pwma_pkg::t_sat                o_sat
);
    import pwma_pkg::*;

    logic adv;

    // Multiply stage.
    logic                     r_m_valid;
    logic signed [P_W-1:0]    r_m_p;
    logic signed [D_W-1:0]    r_m_d;
    logic signed [P_W-1:0]    r_m_kie;
    logic signed [ERR_W-1:0]  r_m_err;
    logic [LVL_W-1:0]         r_m_lvl;

    // Sum stage.
    logic                     r_s_valid;
    logic signed [PD_W-1:0]   r_s_pd;
    logic signed [P_W-1:0]    r_s_kie;
    logic signed [ERR_W-1:0]  r_s_err;
    logic [LVL_W-1:0]         r_s_lvl;

    // Integral stage.
    logic signed [INT_W-1:0]  r_integral;
    logic                     r_a_valid;
    logic signed [PD_W-1:0]   r_a_pd;
    logic signed [INT_W-1:0]  r_a_int;
    t_sat                     r_a_sat;
    logic [LVL_W-1:0]         r_a_lvl;

    // Clamp stage.
    logic                     r_b_valid;
    logic                     r_b_neg;
    logic                     r_b_hi;
    logic [V_W-1:0]           r_b_v;
    t_sat                     r_b_sat;
    logic [LVL_W-1:0]         r_b_lvl;

    // Result register.
    logic                     r_o_valid;
    logic [DUTY_W-1:0]        r_o_duty;
    logic [FILT_W-1:0]        r_o_lvl;
    t_sat                     r_o_sat;

    logic signed [P_W-1:0]    mul_p;
    logic signed [D_W-1:0]    mul_d;
    logic signed [P_W-1:0]    mul_kie;
    logic signed [U_W-1:0]    u_pre;
    t_sat                     sat_pre;
    logic                     hold;
    logic signed [U_W-1:0]    isum;
    logic signed [INT_W-1:0]  isat;
    logic signed [INT_W-1:0]  n_integral;
    logic signed [U_W-1:0]    u_post;
    logic [PROD_W-1:0]        prod;
    logic [DUTY_W-1:0]        n_duty;

    // The whole pipeline moves when the result register is free or being taken.
    assign adv    = !r_o_valid || i_res_pop;
    assign o_take = adv && i_valid;

    // Gain products, with both operands extended to the full product width.
    assign mul_p   = $signed(P_W'({1'b0, i_cfg.kp})) * P_W'($signed(i_item.err));
    assign mul_d   = $signed(D_W'({1'b0, i_cfg.kd})) * D_W'($signed(i_item.derr));
    assign mul_kie = $signed(P_W'({1'b0, i_cfg.ki})) * P_W'($signed(i_item.err));

    // Output before the integral update, and the anti-windup decision.
    assign u_pre   = U_W'(r_s_pd) + U_W'(r_integral);
    assign sat_pre = (u_pre > U_TOP) ? SAT_ABOVE : (u_pre[U_W-1] ? SAT_BELOW : SAT_INSIDE);
    assign hold    = ((sat_pre == SAT_ABOVE) && !r_s_err[ERR_W-1] && (r_s_err != '0))
                  || ((sat_pre == SAT_BELOW) && r_s_err[ERR_W-1]);

    // Integral update with saturation at its width.
    assign isum = U_W'(r_integral) + U_W'(r_s_kie);
    assign isat = (isum[U_W-1] != isum[U_W-2]) ? (isum[U_W-1] ? INT_MIN : INT_MAX)
                                                : isum[INT_W-1:0];
    assign n_integral = hold ? r_integral : isat;

    // Final output with the updated integral.
    assign u_post = U_W'(r_a_pd) + U_W'(r_a_int);

    // Division by the window length through the reciprocal, then the clamp.
    assign prod   = PROD_W'(r_b_v) * PROD_W'(DIV_M);
    assign n_duty = r_b_neg ? '0 : (r_b_hi ? DUTY_W'(DUTY_MAX) : prod[DIV_SH +: DUTY_W]);

    // Valid bits and the integral.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_s_valid  <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_integral <= '0;
        end else if (adv) begin
            r_m_valid <= i_valid;
            r_s_valid <= r_m_valid;
            r_a_valid <= r_s_valid;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
            if (r_s_valid) begin
                r_integral <= n_integral;
            end
        end
    end

    // Payload of each stage.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_p   <= mul_p;
            r_m_d   <= mul_d;
            r_m_kie <= mul_kie;
            r_m_err <= i_item.err;
            r_m_lvl <= i_item.level;

            r_s_pd  <= PD_W'(r_m_p) + PD_W'(r_m_d);
            r_s_kie <= r_m_kie;
            r_s_err <= r_m_err;
            r_s_lvl <= r_m_lvl;

            r_a_pd  <= r_s_pd;
            r_a_int <= n_integral;
            r_a_sat <= sat_pre;
            r_a_lvl <= r_s_lvl;

            r_b_neg <= u_post[U_W-1];
            r_b_hi  <= (u_post > U_LIM);
            r_b_v   <= u_post[GAIN_FRAC_BITS +: V_W];
            r_b_sat <= r_a_sat;
            r_b_lvl <= r_a_lvl;

            r_o_duty <= n_duty;
            r_o_lvl  <= FILT_W'(r_b_lvl);
            r_o_sat  <= r_b_sat;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_duty      = r_o_duty;
    assign o_level     = r_o_lvl;
    assign o_sat       = r_o_sat;

endmodule

@@ dv/tb_pid_with_moving_average_unit.sv @@
module tb_pid_with_moving_average_unit;
    import pwma_pkg::*;

    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    // An index that selects no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;
    localparam logic [GAIN_W-1:0]    GAIN_MAX = '1;

    // One result item of the controller.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [FILT_W-1:0] level;
        t_sat              sat;
    } t_control_out;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    // One step of the directed sequence: a register write or a sample.
    // For samples, data[SAMPLE_BITS-1:0] is the sample; when typed is set the
    // listed result is used instead of the computed one.
    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_IDX_W-1:0] index;
        logic [GAIN_W-1:0] data;
        logic              typed;
        logic [DUTY_W-1:0] duty;
        logic [FILT_W-1:0] level;
        t_sat              sat;
    } t_plan_step;

    localparam int NUM_ROWS = 36;

    // With all gains at zero the output is zero and only the window moves. Then a
    // proportional gain of exactly 4.0 lands u on the saturation threshold, one
    // count more goes above it, and a zero setpoint drives the output negative.
    localparam t_plan_step PLAN [NUM_ROWS] = '{
        '{ROW_WRITE,  REG_KP,       24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KI,       24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KD,       24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b1, 12'd0,    14'd4095,  SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b1, 12'd0,    14'd8190,  SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b1, 12'd0,    14'd12285, SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b1, 12'd0,    14'd16380, SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b1, 12'd0,    14'd12285, SAT_INSIDE},
        '{ROW_WRITE,  REG_SETPOINT, 24'hFFFFFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KP,       24'd262144,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b1, 12'd4095, 14'd12285, SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4094,    1'b1, 12'd4095, 14'd12284, SAT_ABOVE},
        '{ROW_WRITE,  REG_KP,       24'hFFFFFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b1, 12'd4095, 14'd8189,  SAT_ABOVE},
        '{ROW_WRITE,  REG_SETPOINT, 24'hFFF000,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b1, 12'd0,    14'd8189,  SAT_BELOW},
        '{ROW_WRITE,  REG_NONE,     24'hFFFFFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b1, 12'd0,    14'd4094,  SAT_BELOW},
        '{ROW_WRITE,  REG_SETPOINT, 24'(SETPOINT_RST), 1'b0, 12'd0, 14'd0,  SAT_INSIDE},
        '{ROW_WRITE,  REG_KP,       KP_RST,      1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KI,       KI_RST,      1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KD,       KD_RST,      1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KI,       24'hFFFFFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_KD,       24'hFFFFFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_WRITE,  REG_SETPOINT, 24'h000FFF,  1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd0,       1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd4095,    1'b0, 12'd0,    14'd0,     SAT_INSIDE},
        '{ROW_SAMPLE, REG_NONE,     24'd2048,    1'b0, 12'd0,    14'd0,     SAT_INSIDE}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [SAMPLE_BITS-1:0] i_sample = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [DUTY_W-1:0]      o_duty;
    logic [FILT_W-1:0]      o_filtered_level;
    logic [1:0]             o_saturation;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [GAIN_W-1:0]      i_cfg_data = '0;

    pid_with_moving_average_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_sample         (i_sample),
        .empty            (empty),
        .pop              (pop),
        .o_duty           (o_duty),
        .o_filtered_level (o_filtered_level),
        .o_saturation     (o_saturation),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Controller state and registers as the block should hold them.
    logic [SP_W-1:0]        ctl_setpoint = SETPOINT_RST;
    logic [GAIN_W-1:0]      ctl_kp = KP_RST;
    logic [GAIN_W-1:0]      ctl_ki = KI_RST;
    logic [GAIN_W-1:0]      ctl_kd = KD_RST;
    logic [SAMPLE_BITS-1:0] taps [WINDOW_TAPS] = '{default: '0};
    int                     tap_slot = 0;
    int                     tap_sum = 0;
    longint                 last_error = 0;
    longint                 integ_acc = 0;

    t_control_out outputs_due [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           walk_level = 0;
    bit           send_calm = 1'b0;
    bit           pop_calm = 1'b0;
    int           pop_hold = 0;

    // Idle cycles before the next item; calm stretches run with no idling at all.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic void load_gain_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [GAIN_W-1:0] data);
        case (idx)
            REG_SETPOINT: ctl_setpoint = data[SP_W-1:0];
            REG_KP:       ctl_kp = data;
            REG_KI:       ctl_ki = data;
            REG_KD:       ctl_kd = data;
            default: ;
        endcase
    endfunction

    // One control tick: filter the sample, run the PID law with clamping
    // anti-windup, and form the duty.
    function automatic t_control_out run_control_tick(input logic [SAMPLE_BITS-1:0] s);
        t_control_out res;
        longint       err;
        longint       p_term;
        longint       d_term;
        longint       u;
        longint       acc;
        longint       q;
        t_sat         sat;
        tap_sum = tap_sum - int'(taps[tap_slot]) + int'(s);
        taps[tap_slot] = s;
        tap_slot = (tap_slot + 1) % WINDOW_TAPS;

        err = longint'(ctl_setpoint) * WINDOW_TAPS - longint'(tap_sum);
        p_term = longint'(ctl_kp) * err;
        d_term = longint'(ctl_kd) * (err - last_error);
        u = p_term + integ_acc + d_term;
        if (u > TOP_VAL) begin
            sat = SAT_ABOVE;
        end else if (u < 0) begin
            sat = SAT_BELOW;
        end else begin
            sat = SAT_INSIDE;
        end

        // Hold the integral while the output is pinned in the direction of the error.
        if (!(sat == SAT_ABOVE && err > 0) && !(sat == SAT_BELOW && err < 0)) begin
            acc = integ_acc + longint'(ctl_ki) * err;
            if (acc > longint'(INT_MAX)) begin
                acc = longint'(INT_MAX);
            end else if (acc < longint'(INT_MIN)) begin
                acc = longint'(INT_MIN);
            end
            integ_acc = acc;
        end

        u = p_term + integ_acc + d_term;
        if (u < 0) begin
            q = 0;
        end else begin
            q = u / SCALE;
            if (q > DUTY_MAX) begin
                q = DUTY_MAX;
            end
        end
        last_error = err;

        res.duty = DUTY_W'(q);
        res.level = FILT_W'(tap_sum);
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_W'($urandom_range(0, 4096));
            3:       return GAIN_W'($urandom_range(0, 1 << 17));
            4:       return GAIN_W'($urandom_range(0, 1 << 20));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Setpoints near the middle keep the loop out of saturation; the upper data
    // bits are often set to exercise masking.
    function automatic logic [GAIN_W-1:0] pick_setpoint();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_W'($urandom);
            default: return {12'($urandom), 12'($urandom_range(1000, 3000))};
        endcase
    endfunction

    // Mostly a drifting sensor level, with full-range noise and the extremes mixed in.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int step;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SAMPLE_BITS'($urandom);
            default: begin
                step = int'($urandom_range(0, 80)) - 40;
                walk_level = walk_level + step;
                if (walk_level < 0) begin
                    walk_level = 0;
                end else if (walk_level > SAMPLE_MAX) begin
                    walk_level = SAMPLE_MAX;
                end
                return SAMPLE_BITS'(walk_level);
            end
        endcase
    endfunction

    // Registers are written only once every result is out and the pipeline has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        push <= 1'b0;
        while (outputs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        load_gain_reg(idx, data);
    endtask

    // Push keeps its value across back-to-back items so it is never lowered and
    // raised within one step.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                               input t_control_out typed_out);
        int           gap;
        t_control_out res;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        res = run_control_tick(s);
        if (typed) begin
            res = typed_out;
        end
        outputs_due.push_back(res);
    endtask

    initial begin : stimulus
        t_control_out typed_out;
        int           sent;
        int           phase_len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence.
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (PLAN[r].kind == ROW_WRITE) begin
                write_reg(PLAN[r].index, PLAN[r].data);
            end else begin
                typed_out.duty = PLAN[r].duty;
                typed_out.level = PLAN[r].level;
                typed_out.sat = PLAN[r].sat;
                send_sample(PLAN[r].data[SAMPLE_BITS-1:0], PLAN[r].typed, typed_out);
            end
        end

        // Random phases, each under a fresh mix of register values.
        typed_out = '0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_SETPOINT, pick_setpoint());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_KP, pick_gain());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_KI, pick_gain());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_KD, pick_gain());
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_KD) + 1, int'(REG_NONE))),
                          GAIN_W'($urandom));
            end
            walk_level = int'(ctl_setpoint);
            phase_len = $urandom_range(40, 160);
            // The last phase stops at the planned item count.
            if (phase_len > RANDOM_ITEMS - sent) begin
                phase_len = RANDOM_ITEMS - sent;
            end
            repeat (phase_len) begin
                send_sample(pick_sample(), 1'b0, typed_out);
                sent++;
            end
        end

        push <= 1'b0;
        while (outputs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Take result items with random stalls and compare each with the oldest one due.
    always @(posedge i_clk) begin : result_check
        t_control_out want;
        int           stall;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_hold <= 0;
        end else begin
            if (pop && !empty) begin
                if (outputs_due.size() == 0) begin
                    $error("unexpected result item: duty %0d, filtered_level %0d, saturation %0d",
                           o_duty, o_filtered_level, o_saturation);
                    mismatch_count++;
                end else begin
                    want = outputs_due.pop_front();
                    if (o_duty !== want.duty) begin
                        $error("duty: expected %0d, actual %0d", want.duty, o_duty);
                        mismatch_count++;
                    end
                    if (o_filtered_level !== want.level) begin
                        $error("filtered_level: expected %0d, actual %0d",
                               want.level, o_filtered_level);
                        mismatch_count++;
                    end
                    if (o_saturation !== want.sat) begin
                        $error("saturation: expected %0d, actual %0d", want.sat, o_saturation);
                        mismatch_count++;
                    end
                end
                stall = draw_wait(pop_calm);
                pop_hold <= stall;
                pop <= (stall == 0);
            end else if (pop_hold != 0) begin
                pop_hold <= pop_hold - 1;
                pop <= (pop_hold == 1);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
